[rtl/core/buddy_page_allocator_unit_defines.svh]
// Assertion macros for the buddy page allocator.
// Used by the top level; expects clock and reset in scope.
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// Implication in the same cycle.
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/bpa_pkg.sv]
// Shared types and constants of the buddy page allocator.
// No dependencies; used by every module of the block but bpa_ram.
package bpa_pkg;

   localparam int MAX_ORDER   = 10;
   localparam int BLOCK_COUNT = 1024;
   localparam int PAGE_BYTES  = 4096;

   localparam int IDX_W   = 10;
   localparam int LINK_W  = 11;
   localparam int ORD_W   = 4;
   localparam int BYTES_W = 32;
   localparam int HEADS   = MAX_ORDER + 1;

   localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(BLOCK_COUNT);

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TOO_BIG = 2'd1;
   localparam logic [1:0] ST_NO_MEM  = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [BYTES_W-1:0] request_bytes;
      logic [IDX_W-1:0]   block_index;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] granted_index;
      logic [ORD_W-1:0] granted_order;
   } rsp_type;

   typedef struct packed {
      logic              link_we;
      logic [IDX_W-1:0]  link_waddr;
      logic [LINK_W-1:0] link_wdata;
      logic [IDX_W-1:0]  link_raddr;
      logic              ord_we;
      logic [IDX_W-1:0]  ord_waddr;
      logic [ORD_W-1:0]  ord_wdata;
      logic [IDX_W-1:0]  ord_raddr;
   } mem_ctl_type;

endpackage

[rtl/core/bpa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/bpa_size_order.sv]
// Maps a byte count to the smallest block order whose span covers it.
// Depends on bpa_pkg.
module bpa_size_order
   import bpa_pkg::*;
(
   input  logic [BYTES_W-1:0] bytes,
   output logic [ORD_W-1:0]   order,
   output logic               fits
);

   localparam int SPAN_W = BYTES_W + 2;

   always_comb begin
      order = '0;
      fits  = 1'b0;
      // Walk from the top down so that the smallest covering order wins.
      for (int k = MAX_ORDER; k >= 0; k--) begin
         if ({2'b00, bytes} <= (SPAN_W'(PAGE_BYTES) << k)) begin
            order = ORD_W'(k);
            fits  = 1'b1;
         end
      end
   end

endmodule

[rtl/core/bpa_ctrl.sv]
// Sequencer of the buddy allocator: free list heads, list walks, splits and merges.
// Depends on bpa_pkg and bpa_size_order; drives the two RAMs through mem_ctl_type.
module bpa_ctrl
   import bpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           req_data,
   output logic              busy,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   output mem_ctl_type       mem_ctl,
   input  logic [LINK_W-1:0] link_rdata,
   input  logic [ORD_W-1:0]  ord_rdata
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_A_SEL = 4'd1;
   localparam logic [3:0] S_A_POP = 4'd2;
   localparam logic [3:0] S_SPLIT = 4'd3;
   localparam logic [3:0] S_F_RD  = 4'd4;
   localparam logic [3:0] S_F_ORD = 4'd5;
   localparam logic [3:0] S_W_CMP = 4'd6;
   localparam logic [3:0] S_W_RD  = 4'd7;
   localparam logic [3:0] S_W_UNL = 4'd8;
   localparam logic [3:0] S_M_BEG = 4'd9;
   localparam logic [3:0] S_PUSH  = 4'd10;

   logic [3:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [ORD_W-1:0]  ord_ff, ord_in;
   logic [ORD_W-1:0]  src_ff, src_in;
   logic [ORD_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  blk_ff, blk_in;
   logic [IDX_W-1:0]  target_ff, target_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [LINK_W-1:0] cnt_ff, cnt_in;
   logic              take_ff, take_in;
   logic [LINK_W-1:0] head_ff [HEADS];
   logic [LINK_W-1:0] head_in [HEADS];
   logic              clearing_ff, clearing_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [ORD_W-1:0]  size_order;
   logic              size_fits;
   logic              src_found;
   logic [ORD_W-1:0]  src_sel;
   logic [LINK_W-1:0] upper;
   logic [ORD_W-1:0]  k_less;
   logic [IDX_W-1:0]  buddy;

   bpa_size_order u_size (
      .bytes (req_ff.request_bytes),
      .order (size_order),
      .fits  (size_fits)
   );

   // Lowest non-empty list at or above the wanted order.
   always_comb begin
      src_found = 1'b0;
      src_sel   = '0;
      for (int j = MAX_ORDER; j >= 0; j--) begin
         if (ORD_W'(j) >= size_order && head_ff[j] < EMPTY_LINK) begin
            src_found = 1'b1;
            src_sel   = ORD_W'(j);
         end
      end
   end

   assign k_less = k_ff - ORD_W'(1);
   assign upper  = {1'b0, blk_ff} + (LINK_W'(1) << k_less);
   assign buddy  = blk_ff ^ (IDX_W'(1) << ord_ff);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      ord_in       = ord_ff;
      src_in       = src_ff;
      k_in         = k_ff;
      blk_in       = blk_ff;
      target_in    = target_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      cnt_in       = cnt_ff;
      take_in      = take_ff;
      head_in      = head_ff;
      clearing_in  = clearing_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_ctl      = '0;

      if (clearing_ff) begin
         mem_ctl.ord_we     = 1'b1;
         mem_ctl.ord_waddr  = clr_ff;
         mem_ctl.ord_wdata  = (clr_ff == '0) ? ORD_W'(MAX_ORDER) : '0;
         // Block zero sits on the top list from reset, so its link must end the list.
         mem_ctl.link_we    = 1'b1;
         mem_ctl.link_waddr = clr_ff;
         mem_ctl.link_wdata = EMPTY_LINK;
         clr_in             = clr_ff + IDX_W'(1);
         if (clr_ff == IDX_W'(BLOCK_COUNT - 1)) begin
            clearing_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start && !clearing_ff) begin
               req_in   = req_data;
               state_in = (req_data.kind == KIND_ALLOC) ? S_A_SEL : S_F_RD;
            end
         end
         S_A_SEL: begin
            if (!size_fits || !src_found) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: size_fits ? ST_NO_MEM : ST_TOO_BIG,
                                granted_index: '0, granted_order: '0};
               state_in     = S_IDLE;
            end else begin
               ord_in             = size_order;
               src_in             = src_sel;
               k_in               = src_sel;
               blk_in             = head_ff[src_sel][IDX_W-1:0];
               mem_ctl.link_raddr = head_ff[src_sel][IDX_W-1:0];
               state_in           = S_A_POP;
            end
         end
         S_A_POP: begin
            head_in[src_ff] = link_rdata;
            state_in        = S_SPLIT;
         end
         S_SPLIT: begin
            if (k_ff > ord_ff) begin
               if (upper < EMPTY_LINK) begin
                  mem_ctl.ord_we     = 1'b1;
                  mem_ctl.ord_waddr  = upper[IDX_W-1:0];
                  mem_ctl.ord_wdata  = k_less;
                  mem_ctl.link_we    = 1'b1;
                  mem_ctl.link_waddr = upper[IDX_W-1:0];
                  mem_ctl.link_wdata = head_ff[k_less];
                  head_in[k_less]    = upper;
               end
               k_in = k_less;
            end else begin
               mem_ctl.ord_we    = 1'b1;
               mem_ctl.ord_waddr = blk_ff;
               mem_ctl.ord_wdata = ord_ff;
               rsp_valid_in      = 1'b1;
               rsp_in            = '{status: ST_OK, granted_index: blk_ff,
                                     granted_order: ord_ff};
               state_in          = S_IDLE;
            end
         end
         S_F_RD: begin
            mem_ctl.ord_raddr = req_ff.block_index;
            state_in          = S_F_ORD;
         end
         S_F_ORD: begin
            if ({1'b0, req_ff.block_index} >= EMPTY_LINK || ord_rdata > ORD_W'(MAX_ORDER)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_IGNORED, granted_index: '0, granted_order: '0};
               state_in     = S_IDLE;
            end else begin
               ord_in    = ord_rdata;
               blk_in    = req_ff.block_index;
               target_in = req_ff.block_index;
               take_in   = 1'b0;
               cur_in    = head_ff[ord_rdata];
               prev_in   = EMPTY_LINK;
               cnt_in    = '0;
               state_in  = S_W_CMP;
            end
         end
         S_W_CMP: begin
            if (cnt_ff == LINK_W'(BLOCK_COUNT) || cur_ff >= EMPTY_LINK) begin
               // Not on the list: a fresh free goes on to merging, a buddy search stops.
               state_in = take_ff ? S_PUSH : S_M_BEG;
            end else if (cur_ff[IDX_W-1:0] == target_ff) begin
               if (!take_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_IGNORED, granted_index: '0, granted_order: '0};
                  state_in     = S_IDLE;
               end else begin
                  mem_ctl.link_raddr = cur_ff[IDX_W-1:0];
                  state_in           = S_W_UNL;
               end
            end else begin
               mem_ctl.link_raddr = cur_ff[IDX_W-1:0];
               prev_in            = cur_ff;
               cnt_in             = cnt_ff + LINK_W'(1);
               state_in           = S_W_RD;
            end
         end
         S_W_RD: begin
            cur_in   = link_rdata;
            state_in = S_W_CMP;
         end
         S_W_UNL: begin
            if (prev_ff >= EMPTY_LINK) begin
               head_in[ord_ff] = link_rdata;
            end else begin
               mem_ctl.link_we    = 1'b1;
               mem_ctl.link_waddr = prev_ff[IDX_W-1:0];
               mem_ctl.link_wdata = link_rdata;
            end
            if (target_ff < blk_ff) begin
               blk_in = target_ff;
            end
            ord_in   = ord_ff + ORD_W'(1);
            state_in = S_M_BEG;
         end
         S_M_BEG: begin
            if (ord_ff < ORD_W'(MAX_ORDER) && {1'b0, buddy} < EMPTY_LINK) begin
               target_in = buddy;
               take_in   = 1'b1;
               cur_in    = head_ff[ord_ff];
               prev_in   = EMPTY_LINK;
               cnt_in    = '0;
               state_in  = S_W_CMP;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            mem_ctl.ord_we     = 1'b1;
            mem_ctl.ord_waddr  = blk_ff;
            mem_ctl.ord_wdata  = ord_ff;
            mem_ctl.link_we    = 1'b1;
            mem_ctl.link_waddr = blk_ff;
            mem_ctl.link_wdata = head_ff[ord_ff];
            head_in[ord_ff]    = {1'b0, blk_ff};
            rsp_valid_in       = 1'b1;
            rsp_in             = '{status: ST_OK, granted_index: blk_ff,
                                   granted_order: ord_ff};
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < HEADS; j++) begin
            head_ff[j] <= (j == MAX_ORDER) ? '0 : EMPTY_LINK;
         end
      end else begin
         state_ff     <= state_in;
         clearing_ff  <= clearing_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
      end
      req_ff    <= req_in;
      ord_ff    <= ord_in;
      src_ff    <= src_in;
      k_ff      <= k_in;
      blk_ff    <= blk_in;
      target_ff <= target_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      cnt_ff    <= cnt_in;
      take_ff   <= take_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = clearing_ff || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/buddy_page_allocator_unit.sv]
// Buddy page allocator over 1024 pages: one request at a time, one response
// strobe per request. After reset, busy stays high while the block-order and
// link memories are cleared. An allocate request picks a source list, pops
// its head and splits once per level; a free request reads the stored order,
// then walks the free lists (one check walk, then one walk per merge level),
// each step waiting on the registered link memory read. The response appears
// for exactly one cycle on rsp_valid and cannot be held off by the receiver.
// Depends on bpa_pkg, bpa_ram, bpa_ctrl and the assertion macro header.
`include "buddy_page_allocator_unit_defines.svh"

module buddy_page_allocator_unit
   import bpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   mem_ctl_type       mem_ctl;
   logic [LINK_W-1:0] link_rdata;
   logic [ORD_W-1:0]  ord_rdata;

   bpa_ram #(.WIDTH(LINK_W), .DEPTH(BLOCK_COUNT)) u_link_ram (
      .clock (clock),
      .we    (mem_ctl.link_we),
      .waddr (mem_ctl.link_waddr),
      .wdata (mem_ctl.link_wdata),
      .raddr (mem_ctl.link_raddr),
      .rdata (link_rdata)
   );

   bpa_ram #(.WIDTH(ORD_W), .DEPTH(BLOCK_COUNT)) u_order_ram (
      .clock (clock),
      .we    (mem_ctl.ord_we),
      .waddr (mem_ctl.ord_waddr),
      .wdata (mem_ctl.ord_wdata),
      .raddr (mem_ctl.ord_raddr),
      .rdata (ord_rdata)
   );

   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .mem_ctl    (mem_ctl),
      .link_rdata (link_rdata),
      .ord_rdata  (ord_rdata)
   );

   `BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
   `BPA_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid, "response strobe longer than one cycle")
   `BPA_ASSERT_NOW(a_err_zero, rsp_valid && rsp_data.status != ST_OK, rsp_data.granted_index == '0 && rsp_data.granted_order == '0, "error response carries data")
   `BPA_ASSERT_NOW(a_order_range, rsp_valid, rsp_data.granted_order <= ORD_W'(MAX_ORDER), "granted order out of range")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the buddy page allocator: a directed table,
// then random allocate/free traffic, each response checked against the table
// or its model of the free lists. Depends on bpa_pkg and the allocator RTL.
module tb_top;
   import bpa_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int RANDOM_ITEMS   = 1900;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } row_type;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Model state: free list heads, links and stored block orders.
   logic [LINK_W-1:0] pool_head [HEADS];
   logic [LINK_W-1:0] pool_link [BLOCK_COUNT];
   logic [ORD_W-1:0]  pool_order [BLOCK_COUNT];

   rsp_type   grants_due [$];
   int        live_blocks [$];
   row_type   directed_rows [$];
   int        mismatches;
   int        idle_cycles;

   buddy_page_allocator_unit dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Walks list ord for blk, unlinking it when take is set.
   function automatic bit seek_block(int ord, int blk, bit take);
      int prev;
      int cur;
      prev = BLOCK_COUNT;
      cur = pool_head[ord];
      for (int n = 0; n < BLOCK_COUNT && cur < BLOCK_COUNT; n++) begin
         if (cur == blk) begin
            if (take) begin
               if (prev >= BLOCK_COUNT) pool_head[ord] = pool_link[cur];
               else pool_link[prev] = pool_link[cur];
            end
            return 1'b1;
         end
         prev = cur;
         cur = pool_link[cur];
      end
      return 1'b0;
   endfunction

   function automatic void push_block(int ord, int blk);
      pool_link[blk] = pool_head[ord];
      pool_head[ord] = LINK_W'(blk);
   endfunction

   function automatic rsp_type predict_grant(req_type rq);
      rsp_type r;
      longint  span;
      int      ord;
      int      src;
      int      blk;
      int      upper;
      r = '0;
      if (rq.kind == KIND_ALLOC) begin
         ord = 0;
         span = PAGE_BYTES;
         while (ord <= MAX_ORDER && longint'(rq.request_bytes) > span) begin
            ord++;
            span = span << 1;
         end
         if (ord > MAX_ORDER) begin
            r.status = ST_TOO_BIG;
            return r;
         end
         src = ord;
         while (src <= MAX_ORDER && pool_head[src] >= BLOCK_COUNT) src++;
         if (src > MAX_ORDER) begin
            r.status = ST_NO_MEM;
            return r;
         end
         blk = pool_head[src];
         pool_head[src] = pool_link[blk];
         for (int k = src; k > ord; k--) begin
            upper = blk + (1 << (k - 1));
            if (upper < BLOCK_COUNT) begin
               pool_order[upper] = ORD_W'(k - 1);
               push_block(k - 1, upper);
            end
         end
         pool_order[blk] = ORD_W'(ord);
         r.status = ST_OK;
         r.granted_index = IDX_W'(blk);
         r.granted_order = ORD_W'(ord);
      end else begin
         blk = rq.block_index;
         ord = pool_order[blk];
         if (ord > MAX_ORDER || seek_block(ord, blk, 1'b0)) begin
            r.status = ST_IGNORED;
            return r;
         end
         while (ord < MAX_ORDER) begin
            upper = blk ^ (1 << ord);
            if (upper >= BLOCK_COUNT || !seek_block(ord, upper, 1'b1)) break;
            if (upper < blk) blk = upper;
            ord++;
         end
         pool_order[blk] = ORD_W'(ord);
         push_block(ord, blk);
         r.status = ST_OK;
         r.granted_index = IDX_W'(blk);
         r.granted_order = ORD_W'(ord);
      end
      return r;
   endfunction

   function automatic void add_row(logic kind, logic [BYTES_W-1:0] bytes,
                                   logic [IDX_W-1:0] idx, bit typed,
                                   logic [1:0] st, int gi, int go);
      row_type row;
      row.req.kind = kind;
      row.req.request_bytes = bytes;
      row.req.block_index = idx;
      row.typed = typed;
      row.rsp.status = st;
      row.rsp.granted_index = IDX_W'(gi);
      row.rsp.granted_order = ORD_W'(go);
      directed_rows.push_back(row);
   endfunction

   // Mostly well-formed traffic: sized allocations and frees of live blocks.
   function automatic req_type make_request();
      req_type rq;
      int      ord;
      int      pick;
      rq.kind = KIND_ALLOC;
      rq.request_bytes = $urandom;
      rq.block_index = IDX_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         ord = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_ORDER)
                                           : $urandom_range(0, 3);
         if (ord == 0) rq.request_bytes = $urandom_range(0, PAGE_BYTES);
         else rq.request_bytes = $urandom_range((PAGE_BYTES << (ord - 1)) + 1,
                                                PAGE_BYTES << ord);
      end else if (pick < 50) begin
         rq.request_bytes = $urandom;
      end else if (pick < 92 && live_blocks.size() > 0) begin
         ord = $urandom_range(0, live_blocks.size() - 1);
         rq.kind = KIND_FREE;
         rq.block_index = IDX_W'(live_blocks[ord]);
         live_blocks.delete(ord);
      end else begin
         rq.kind = KIND_FREE;
      end
      return rq;
   endfunction

   task automatic send_request(req_type rq, bit typed, rsp_type typed_rsp, bit quiet);
      rsp_type r;
      if (!quiet && $urandom_range(0, 99) < 11) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      r = predict_grant(rq);
      if (rq.kind == KIND_ALLOC && r.status == ST_OK) live_blocks.push_back(r.granted_index);
      grants_due.push_back(typed ? typed_rsp : r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
         if (rsp_valid) begin
            if (grants_due.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               if (rsp_data.status !== grants_due[0].status) begin
                  $error("status expected %0d got %0d", grants_due[0].status,
                         rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.granted_index !== grants_due[0].granted_index) begin
                  $error("granted_index expected %0d got %0d",
                         grants_due[0].granted_index, rsp_data.granted_index);
                  mismatches++;
               end
               if (rsp_data.granted_order !== grants_due[0].granted_order) begin
                  $error("granted_order expected %0d got %0d",
                         grants_due[0].granted_order, rsp_data.granted_order);
                  mismatches++;
               end
               void'(grants_due.pop_front());
            end
         end
      end
   end

   initial begin
      rsp_type none;
      none = '0;
      mismatches = 0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      for (int k = 0; k < HEADS; k++) pool_head[k] = EMPTY_LINK;
      for (int i = 0; i < BLOCK_COUNT; i++) begin
         pool_link[i] = EMPTY_LINK;
         pool_order[i] = '0;
      end
      pool_order[0] = ORD_W'(MAX_ORDER);
      pool_head[MAX_ORDER] = 0;

      // From reset: a zero-byte request splits the whole pool down to page 0.
      add_row(KIND_ALLOC, 32'd0, 10'h3FF, 1, ST_OK, 0, 0);
      add_row(KIND_ALLOC, 32'd4096, 10'd0, 1, ST_OK, 1, 0);
      add_row(KIND_ALLOC, 32'd4097, 10'd0, 1, ST_OK, 2, 1);
      add_row(KIND_ALLOC, 32'hFFFF_FFFF, 10'd0, 1, ST_TOO_BIG, 0, 0);
      add_row(KIND_ALLOC, 32'd4194305, 10'd0, 1, ST_TOO_BIG, 0, 0);
      add_row(KIND_FREE, 32'hFFFF_FFFF, 10'd1023, 0, ST_OK, 0, 0);
      add_row(KIND_FREE, 32'd0, 10'd1023, 1, ST_IGNORED, 0, 0);
      add_row(KIND_FREE, 32'd0, 10'd1, 0, ST_OK, 0, 0);
      add_row(KIND_FREE, 32'd0, 10'd0, 0, ST_OK, 0, 0);
      add_row(KIND_FREE, 32'd0, 10'd2, 0, ST_OK, 0, 0);
      add_row(KIND_FREE, 32'd0, 10'd2, 0, ST_OK, 0, 0);
      add_row(KIND_FREE, 32'd0, 10'd1023, 0, ST_OK, 0, 0);
      add_row(KIND_ALLOC, 32'd4194304, 10'd0, 0, ST_OK, 0, 0);
      add_row(KIND_ALLOC, 32'd4194304, 10'd0, 0, ST_OK, 0, 0);
      add_row(KIND_ALLOC, 32'd1, 10'd0, 0, ST_OK, 0, 0);
      add_row(KIND_FREE, 32'd0, 10'd0, 0, ST_OK, 0, 0);
      add_row(KIND_ALLOC, 32'd2097152, 10'd0, 0, ST_OK, 0, 0);
      add_row(KIND_ALLOC, 32'd2097153, 10'd0, 0, ST_OK, 0, 0);
      add_row(KIND_FREE, 32'd0, 10'd512, 0, ST_OK, 0, 0);
      add_row(KIND_FREE, 32'd0, 10'd0, 0, ST_OK, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed,
                      directed_rows[i].rsp, 1'b0);
      for (int i = 0; i < RANDOM_ITEMS; i++)
         send_request(make_request(), 1'b0, none, i >= 700 && i < 1100);
      start <= 1'b0;

      while (grants_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/bpa_size_order.sv
rtl/core/bpa_ctrl.sv
rtl/core/buddy_page_allocator_unit.sv
sim/tb_top.sv
